@@ sv/wpt_pkg.sv @@
package wpt_pkg;

	localparam int MAX_WAYPOINTS_DEF = 64;

	localparam int COORD_W  = 32;
	localparam int INDEX_W  = 6;
	localparam int COUNT_W  = 7;
	localparam int RADIUS_W = 31;
	localparam int DIST_W   = 64;

	typedef logic [1:0] cmd_t;

	localparam cmd_t CMD_WRITE   = 2'd0;
	localparam cmd_t CMD_POSE    = 2'd1;
	localparam cmd_t CMD_RESTART = 2'd2;

	typedef logic cfg_idx_t;

	localparam cfg_idx_t CFG_WAYPOINT_COUNT = 1'b0;
	localparam cfg_idx_t CFG_REACH_RADIUS   = 1'b1;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic [COORD_W-1:0] mag_t;
	typedef logic [DIST_W-1:0] dist_t;

	function automatic mag_t abs_diff(input coord_t a, input coord_t b);
		logic [COORD_W:0] d_ab;
		logic [COORD_W:0] d_ba;
		d_ab = {a[COORD_W-1], a} - {b[COORD_W-1], b};
		d_ba = {b[COORD_W-1], b} - {a[COORD_W-1], a};
		return (a >= b) ? d_ab[COORD_W-1:0] : d_ba[COORD_W-1:0];
	endfunction

	function automatic dist_t sat_add(input dist_t a, input dist_t b);
		logic [DIST_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[DIST_W] ? {DIST_W{1'b1}} : s[DIST_W-1:0];
	endfunction

endpackage

@@ sv/waypoint_progress_tracker_unit.sv @@
// Channel   Direction  Handshake            Payload
// request   in         in_valid / in_stall  cmd, entry_index, pos_x, pos_y
// result    out        out_valid / out_stall target_index, arrived, passed_valid,
//                                           passed_index, within_radius, advanced, status
// config    in         cfg_we               cfg_index, cfg_data
//
// A request passes from its input register to a registered result through difference
// magnitudes, squares, then the distance compare that updates the tracking state and loads
// the result register. Poses can be accepted every cycle when not stalled. A table write or
// a restart holds off new requests until it has updated the state, and a pose waits in the
// input register after any change of target or table until the read ports hold new waypoints.
// Reset is asynchronous and leaves the table as it was; a stalled result keeps its value.
module waypoint_progress_tracker_unit #(
	parameter int MAX_WAYPOINTS = wpt_pkg::MAX_WAYPOINTS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  wpt_pkg::cmd_t                       cmd,
	input  logic [wpt_pkg::INDEX_W-1:0]         entry_index,
	input  logic signed [wpt_pkg::COORD_W-1:0]  pos_x,
	input  logic signed [wpt_pkg::COORD_W-1:0]  pos_y,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [wpt_pkg::INDEX_W-1:0]         target_index,
	output logic                                arrived,
	output logic                                passed_valid,
	output logic [wpt_pkg::INDEX_W-1:0]         passed_index,
	output logic                                within_radius,
	output logic                                advanced,
	output logic                                status,
	input  logic                                cfg_we,
	input  wpt_pkg::cfg_idx_t                   cfg_index,
	input  logic [wpt_pkg::RADIUS_W-1:0]        cfg_data
);
	import wpt_pkg::*;

	localparam int AW = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;

	logic [COORD_W-1:0] mem_x [MAX_WAYPOINTS];
	logic [COORD_W-1:0] mem_y [MAX_WAYPOINTS];

	logic [AW-1:0]       tgt_q;
	logic                done_q;
	logic                reached_q;
	dist_t               closest_q;
	logic [COUNT_W-1:0]  cnt_q;
	logic [RADIUS_W-1:0] radius_q;
	dist_t               thr_q;
	logic                fresh_q;

	logic [COORD_W-1:0] rd0_x_q, rd0_y_q, rd1_x_q, rd1_y_q;
	logic [AW-1:0]      nxt_addr;

	logic               v_s1, v_s2, v_s3;
	cmd_t               cmd_s1, cmd_s2, cmd_s3;
	logic [INDEX_W-1:0] idx_s1, idx_s2, idx_s3;
	coord_t             x_s1, y_s1, x_s2, y_s2, x_s3, y_s3;
	logic [AW-1:0]      tag_s2, tag_s3;
	mag_t               mcx_s2, mcy_s2, mnx_s2, mny_s2;
	dist_t              sqcx_s3, sqcy_s3, sqnx_s3, sqny_s3;

	logic               ov_q;
	logic [INDEX_W-1:0] target_index_q, passed_index_q;
	logic               arrived_q, passed_valid_q, within_radius_q, advanced_q, status_q;

	logic accept, mv1, mv2, mv3, free1, free2, free3, hazard;
	logic cfg_cnt_we;
	logic [COUNT_W-1:0] cfg_cnt;

	logic [AW-1:0]  tgt_d;
	logic           done_d, reached_d, adv, wr_en, chg;
	dist_t          closest_d, dist_c, dist_n, dist_sel;
	logic           slot_ok;

	assign free3  = !v_s3 || !ov_q || !out_stall;
	assign mv3    = v_s3 && (!ov_q || !out_stall);
	assign mv2    = v_s2 && free3;
	assign free2  = !v_s2 || free3;
	assign mv1    = v_s1 && free2 && (cmd_s1 != CMD_POSE || fresh_q);
	assign free1  = !v_s1 || mv1;
	assign hazard = (v_s1 && (cmd_s1 == CMD_WRITE || cmd_s1 == CMD_RESTART))
		|| (v_s2 && (cmd_s2 == CMD_WRITE || cmd_s2 == CMD_RESTART))
		|| (v_s3 && (cmd_s3 == CMD_WRITE || cmd_s3 == CMD_RESTART));
	assign in_stall = !free1 || hazard;
	assign accept   = in_valid && !in_stall;

	assign cfg_cnt_we = cfg_we && (cfg_index == CFG_WAYPOINT_COUNT);
	assign cfg_cnt = (32'(cfg_data[COUNT_W-1:0]) > 32'(MAX_WAYPOINTS))
		? COUNT_W'(MAX_WAYPOINTS) : cfg_data[COUNT_W-1:0];

	assign nxt_addr = tgt_q + AW'(1);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_x[AW'(idx_s3)] <= x_s3;
			mem_y[AW'(idx_s3)] <= y_s3;
		end
		rd0_x_q <= mem_x[tgt_q];
		rd0_y_q <= mem_y[tgt_q];
		rd1_x_q <= mem_x[nxt_addr];
		rd1_y_q <= mem_y[nxt_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			v_s1 <= accept || (v_s1 && !mv1);
			v_s2 <= mv1 || (v_s2 && !mv2);
			v_s3 <= mv2 || (v_s3 && !mv3);
			ov_q <= mv3 || (ov_q && out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd;
			idx_s1 <= entry_index;
			x_s1   <= pos_x;
			y_s1   <= pos_y;
		end
		if (mv1) begin
			cmd_s2 <= cmd_s1;
			idx_s2 <= idx_s1;
			x_s2   <= x_s1;
			y_s2   <= y_s1;
			tag_s2 <= tgt_q;
			mcx_s2 <= abs_diff(x_s1, $signed(rd0_x_q));
			mcy_s2 <= abs_diff(y_s1, $signed(rd0_y_q));
			mnx_s2 <= abs_diff(x_s1, $signed(rd1_x_q));
			mny_s2 <= abs_diff(y_s1, $signed(rd1_y_q));
		end
		if (mv2) begin
			cmd_s3  <= cmd_s2;
			idx_s3  <= idx_s2;
			x_s3    <= x_s2;
			y_s3    <= y_s2;
			tag_s3  <= tag_s2;
			sqcx_s3 <= DIST_W'(mcx_s2) * DIST_W'(mcx_s2);
			sqcy_s3 <= DIST_W'(mcy_s2) * DIST_W'(mcy_s2);
			sqnx_s3 <= DIST_W'(mnx_s2) * DIST_W'(mnx_s2);
			sqny_s3 <= DIST_W'(mny_s2) * DIST_W'(mny_s2);
		end
		thr_q <= DIST_W'(radius_q) * DIST_W'(radius_q);
	end

	always_comb begin
		tgt_d     = tgt_q;
		done_d    = done_q;
		reached_d = reached_q;
		closest_d = closest_q;
		adv       = 1'b0;
		wr_en     = 1'b0;
		slot_ok   = 32'(idx_s3) < 32'(MAX_WAYPOINTS);
		dist_c    = sat_add(sqcx_s3, sqcy_s3);
		dist_n    = sat_add(sqnx_s3, sqny_s3);
		dist_sel  = (tgt_q == tag_s3) ? dist_c : dist_n;
		if (mv3) begin
			unique case (cmd_s3)
				CMD_WRITE, CMD_RESTART: begin
					wr_en     = (cmd_s3 == CMD_WRITE) && slot_ok;
					tgt_d     = '0;
					done_d    = 1'b0;
					reached_d = 1'b0;
					closest_d = '1;
				end
				CMD_POSE: begin
					if (cnt_q != '0 && !done_q) begin
						if (reached_q && dist_sel > closest_q) begin
							adv = 1'b1;
							if (32'(tgt_q) + 32'd1 < 32'(cnt_q)) begin
								tgt_d     = tgt_q + AW'(1);
								reached_d = 1'b0;
								closest_d = '1;
							end else begin
								done_d = 1'b1;
							end
						end else begin
							if (dist_sel < closest_q) begin
								closest_d = dist_sel;
							end
							if (dist_sel <= thr_q) begin
								reached_d = 1'b1;
							end
						end
					end
				end
				default: begin
				end
			endcase
		end
		chg = wr_en || (tgt_d != tgt_q) || cfg_cnt_we;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tgt_q     <= '0;
			done_q    <= 1'b0;
			reached_q <= 1'b0;
			closest_q <= '1;
			cnt_q     <= '0;
			radius_q  <= '0;
			fresh_q   <= 1'b0;
		end else begin
			fresh_q <= !chg;
			if (cfg_cnt_we) begin
				cnt_q     <= cfg_cnt;
				tgt_q     <= '0;
				done_q    <= 1'b0;
				reached_q <= 1'b0;
				closest_q <= '1;
			end else begin
				tgt_q     <= tgt_d;
				done_q    <= done_d;
				reached_q <= reached_d;
				closest_q <= closest_d;
			end
			if (cfg_we && cfg_index == CFG_REACH_RADIUS) begin
				radius_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mv3) begin
			if (cnt_q == '0) begin
				target_index_q  <= '0;
				arrived_q       <= 1'b0;
				passed_valid_q  <= 1'b0;
				passed_index_q  <= '0;
				within_radius_q <= 1'b0;
				advanced_q      <= 1'b0;
				status_q        <= 1'b1;
			end else begin
				target_index_q  <= done_d ? '0 : INDEX_W'(tgt_d);
				arrived_q       <= done_d;
				passed_valid_q  <= done_d || (tgt_d != '0);
				if (done_d) begin
					passed_index_q <= INDEX_W'(cnt_q - COUNT_W'(1));
				end else if (tgt_d != '0) begin
					passed_index_q <= INDEX_W'(tgt_d - AW'(1));
				end else begin
					passed_index_q <= '0;
				end
				within_radius_q <= reached_d;
				advanced_q      <= adv;
				status_q        <= 1'b0;
			end
		end
	end

	assign out_valid     = ov_q;
	assign target_index  = target_index_q;
	assign arrived       = arrived_q;
	assign passed_valid  = passed_valid_q;
	assign passed_index  = passed_index_q;
	assign within_radius = within_radius_q;
	assign advanced      = advanced_q;
	assign status        = status_q;

`ifndef SYNTHESIS
	// A pose is measured against the target it saw in the first stage or the one after it.
	a_tag_window: assert property (@(posedge clk) disable iff (!arst_n)
		(mv3 && cmd_s3 == CMD_POSE)
		|-> (tgt_q == tag_s3 || {1'b0, tgt_q} == {1'b0, tag_s3} + 1'b1))
		else $error("pose committed against a stale target");

	a_tgt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != '0 && !done_q) |-> (32'(tgt_q) < 32'(cnt_q)))
		else $error("target beyond waypoint count");

	a_adv_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(mv3 && adv && !done_d && !cfg_cnt_we) |=> (!reached_q && closest_q == '1))
		else $error("advance did not clear progress");
`endif

endmodule
